>>> rtl/rwtc_pkg.sv
// shared constants for the wall texture coordinate core
`default_nettype none

package rwtc_pkg;

   // hit face codes
   localparam logic [1:0] SIDE_NORTH = 2'd0;
   localparam logic [1:0] SIDE_SOUTH = 2'd1;
   localparam logic [1:0] SIDE_WEST  = 2'd2;
   localparam logic [1:0] SIDE_EAST  = 2'd3;

   // register indexes of the csr port
   localparam int          CSR_IDX_W      = 1;
   localparam logic [0:0]  CSR_TEX_WIDTH  = 1'd0;
   localparam logic [0:0]  CSR_TEX_HEIGHT = 1'd1;
   localparam int          CSR_DATA_W     = 11;
   localparam logic [10:0] TEX_RESET      = 11'd64;

   // field widths
   localparam int SIDE_W = 2;
   localparam int POS_W  = 32;
   localparam int DIST_W = 31;
   localparam int DIR_W  = 32;
   localparam int LH_W   = 16;
   localparam int DS_W   = 12;
   localparam int WF_W   = 16;
   localparam int TEXX_W = 10;
   localparam int STEP_W = 27;
   localparam int TPOS_W = 48;
   localparam int ROW_W  = 18;

   localparam logic [STEP_W-1:0] STEP_MAX = {STEP_W{1'b1}};

   // request word layout, lowest bit first
   localparam int PX_LSB   = 0;
   localparam int PY_LSB   = PX_LSB + POS_W;
   localparam int DIST_LSB = PY_LSB + POS_W;
   localparam int RDX_LSB  = DIST_LSB + DIST_W;
   localparam int RDY_LSB  = RDX_LSB + DIR_W;
   localparam int LH_LSB   = RDY_LSB + DIR_W;
   localparam int DS_LSB   = LH_LSB + LH_W;
   localparam int REQ_W    = DS_LSB + DS_W;
   localparam int REQ_DATA_W = ((REQ_W + 7) / 8) * 8;

   // response word layout, lowest bit first
   localparam int WF_LSB   = 0;
   localparam int TEXX_LSB = WF_LSB + WF_W;
   localparam int STEP_LSB = TEXX_LSB + TEXX_W;
   localparam int TPOS_LSB = STEP_LSB + STEP_W;
   localparam int RSP_W    = TPOS_LSB + TPOS_W;
   localparam int RSP_DATA_W = ((RSP_W + 7) / 8) * 8;

endpackage : rwtc_pkg

`default_nettype wire

>>> rtl/raycast_wall_texture_coord_core.sv
// wall texture coordinate core: hit fraction, texture column, step and start row
// request words pass through a registered pipeline to the response word; fixed point is Q16.16 by default,
// and the restoring divider retires one quotient bit per stage
// throughput: one word per cycle while rsp_tready is high; stages holding no word refill while the output waits
// reset: synchronous, clears all stage valid bits and sets both texture sizes to 64
`default_nettype none

module raycast_wall_texture_coord_core #(
   parameter int SCREEN_HEIGHT = 1024,
   parameter int FRAC_BITS     = 16
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   // request stream
   input  wire logic                                   req_tvalid,
   output      logic                                   req_tready,
   // player_x, player_y, wall_distance, ray_dir_x, ray_dir_y, line_height, draw_start
   input  wire logic [rwtc_pkg::REQ_DATA_W-1:0]        req_tdata,
   // side
   input  wire logic [rwtc_pkg::SIDE_W-1:0]            req_tuser,
   // response stream
   output      logic                                   rsp_tvalid,
   input  wire logic                                   rsp_tready,
   // wall_frac, tex_x, tex_step, tex_pos
   output      logic [rwtc_pkg::RSP_DATA_W-1:0]        rsp_tdata,
   // csr write port
   input  wire logic                                   csr_wen,
   input  wire logic [rwtc_pkg::CSR_IDX_W-1:0]         csr_index,
   input  wire logic [rwtc_pkg::CSR_DATA_W-1:0]        csr_wdata
);

   import rwtc_pkg::*;

   localparam int QW = 11 + FRAC_BITS;   // quotient width, one divider stage per bit
   localparam int NS = QW + 2;           // total stages
   localparam int FP_W = FRAC_BITS + 11;
   localparam int CW = (QW > STEP_W) ? QW : STEP_W;
   localparam logic signed [ROW_W-1:0] HALF_SCREEN = ROW_W'(SCREEN_HEIGHT / 2);

   // configuration registers
   logic [10:0] tex_width_ff, tex_height_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tex_width_ff  <= TEX_RESET;
         tex_height_ff <= TEX_RESET;
      end else if (csr_wen) begin
         case (csr_index)
            CSR_TEX_WIDTH:  tex_width_ff  <= csr_wdata;
            CSR_TEX_HEIGHT: tex_height_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // stage valid bits and load enables; a stage loads when rsp_tready is high or any stage at or after it is empty
   logic [NS:1] v_ff;
   logic [NS:1] en;

   for (genvar k = 1; k <= NS; k++) begin : g_en
      assign en[k] = rsp_tready || !(&v_ff[NS:k]);
   end

   assign req_tready = en[1];
   assign rsp_tvalid = v_ff[NS];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (en[1]) begin
            v_ff[1] <= req_tvalid;
         end
         for (int k = 2; k <= NS; k++) begin
            if (en[k]) begin
               v_ff[k] <= v_ff[k-1];
            end
         end
      end
   end

   // request word unpack
   logic [1:0]              in_side;
   logic signed [POS_W-1:0] in_px, in_py, in_rdx, in_rdy;
   logic [DIST_W-1:0]       in_dist;
   logic [LH_W-1:0]         in_lh;
   logic [DS_W-1:0]         in_ds;

   assign in_side = req_tuser;
   assign in_px   = req_tdata[PX_LSB +: POS_W];
   assign in_py   = req_tdata[PY_LSB +: POS_W];
   assign in_dist = req_tdata[DIST_LSB +: DIST_W];
   assign in_rdx  = req_tdata[RDX_LSB +: DIR_W];
   assign in_rdy  = req_tdata[RDY_LSB +: DIR_W];
   assign in_lh   = req_tdata[LH_LSB +: LH_W];
   assign in_ds   = req_tdata[DS_LSB +: DS_W];

   // axis select, mirror flag, fixed-up height and row offset
   logic                    in_ew, in_mirror;
   logic signed [POS_W-1:0] in_pos, in_dir;
   logic [LH_W-1:0]         in_lh_fix;
   logic signed [ROW_W-1:0] in_row;
   logic signed [63:0]      in_prod;

   always_comb begin
      in_ew     = in_side inside {SIDE_WEST, SIDE_EAST};
      in_pos    = in_ew ? in_py : in_px;
      in_dir    = in_ew ? in_rdy : in_rdx;
      in_mirror = in_ew ? in_rdx[POS_W-1] : (!in_rdy[POS_W-1] && (in_rdy != '0));
      in_lh_fix = (in_lh == '0) ? LH_W'(1) : in_lh;
      in_row    = $signed({{(ROW_W-DS_W){1'b0}}, in_ds}) - HALF_SCREEN
                + $signed({{(ROW_W-LH_W+1){1'b0}}, in_lh_fix[LH_W-1:1]});
      in_prod   = $signed({1'b0, in_dist}) * in_dir;
   end

   // stage 1: distance times direction, kept to the low 2F bits
   logic [2*FRAC_BITS-1:0] prod1_ff;
   logic [FRAC_BITS-1:0]   posf1_ff;
   logic                   mir1_ff;

   always_ff @(posedge clock) begin
      if (en[1]) begin
         prod1_ff <= in_prod[2*FRAC_BITS-1:0];
         posf1_ff <= in_pos[FRAC_BITS-1:0];
         mir1_ff  <= in_mirror;
      end
   end

   // stage 2: add position, take the fraction bits
   logic [2*FRAC_BITS-1:0] sum2_in;
   logic [FRAC_BITS-1:0]   frac2_ff;
   logic                   mir2_ff;

   assign sum2_in = prod1_ff + {posf1_ff, {FRAC_BITS{1'b0}}};

   always_ff @(posedge clock) begin
      if (en[2]) begin
         frac2_ff <= sum2_in[2*FRAC_BITS-1:FRAC_BITS];
         mir2_ff  <= mir1_ff;
      end
   end

   // stage 3: fraction times texture width
   logic [FP_W-1:0]      fp3_ff;
   logic [FRAC_BITS-1:0] frac3_ff;
   logic                 mir3_ff;

   always_ff @(posedge clock) begin
      if (en[3]) begin
         fp3_ff   <= frac2_ff * tex_width_ff;
         frac3_ff <= frac2_ff;
         mir3_ff  <= mir2_ff;
      end
   end

   // stage 4: texture column with mirroring, then carried to the divider end
   logic [10:0]        col4;
   logic [10:0]        tx4_in;
   logic [WF_W-1:0]    wf_ff [4:QW];
   logic [TEXX_W-1:0]  tx_ff [4:QW];

   assign col4   = fp3_ff[FP_W-1:FRAC_BITS];
   assign tx4_in = mir3_ff ? (tex_width_ff - col4 - 11'd1) : col4;

   always_ff @(posedge clock) begin
      if (en[4]) begin
         wf_ff[4] <= WF_W'(frac3_ff);
         tx_ff[4] <= tx4_in[TEXX_W-1:0];
      end
      for (int k = 5; k <= QW; k++) begin
         if (en[k]) begin
            wf_ff[k] <= wf_ff[k-1];
            tx_ff[k] <= tx_ff[k-1];
         end
      end
   end

   // restoring divider: (tex_height << F) / line_height, one quotient bit per stage
   logic [LH_W-1:0]         rem_ff [1:QW];
   logic [QW-1:0]           quo_ff [1:QW];
   logic [LH_W-1:0]         dvs_ff [1:QW];
   logic signed [ROW_W-1:0] row_ff [1:QW];

   for (genvar k = 1; k <= QW; k++) begin : g_div
      localparam int B = QW - k;
      logic [LH_W-1:0]         rem_prev, dvs_prev;
      logic [QW-1:0]           quo_prev;
      logic signed [ROW_W-1:0] row_prev;
      logic                    nbit;
      logic [LH_W:0]           trial, diff;
      logic                    ge;

      if (k == 1) begin : g_first
         assign rem_prev = '0;
         assign quo_prev = '0;
         assign dvs_prev = in_lh_fix;
         assign row_prev = in_row;
      end else begin : g_next
         assign rem_prev = rem_ff[k-1];
         assign quo_prev = quo_ff[k-1];
         assign dvs_prev = dvs_ff[k-1];
         assign row_prev = row_ff[k-1];
      end

      if (B >= FRAC_BITS) begin : g_hbit
         assign nbit = tex_height_ff[B-FRAC_BITS];
      end else begin : g_zbit
         assign nbit = 1'b0;
      end

      assign trial = {rem_prev, nbit};
      assign ge    = trial >= {1'b0, dvs_prev};
      assign diff  = trial - {1'b0, dvs_prev};

      always_ff @(posedge clock) begin
         if (en[k]) begin
            rem_ff[k] <= ge ? diff[LH_W-1:0] : trial[LH_W-1:0];
            quo_ff[k] <= {quo_prev[QW-2:0], ge};
            dvs_ff[k] <= dvs_prev;
            row_ff[k] <= row_prev;
         end
      end
   end

   // stage QW+1: saturate the step
   logic [CW-1:0]           quo_ext;
   logic [STEP_W-1:0]       step_sat;
   logic [STEP_W-1:0]       step_ff;
   logic signed [ROW_W-1:0] row_q_ff;
   logic [WF_W-1:0]         wf_q_ff;
   logic [TEXX_W-1:0]       tx_q_ff;

   assign quo_ext  = CW'(quo_ff[QW]);
   assign step_sat = (quo_ext > CW'(STEP_MAX)) ? STEP_MAX : quo_ext[STEP_W-1:0];

   always_ff @(posedge clock) begin
      if (en[QW+1]) begin
         step_ff  <= step_sat;
         row_q_ff <= row_ff[QW];
         wf_q_ff  <= wf_ff[QW];
         tx_q_ff  <= tx_ff[QW];
      end
   end

   // stage QW+2: start row times step into the output word
   logic signed [ROW_W+STEP_W:0] tpos_prod;
   logic [RSP_DATA_W-1:0]        rsp_data_ff;

   assign tpos_prod = row_q_ff * $signed({1'b0, step_ff});

   always_ff @(posedge clock) begin
      if (en[NS]) begin
         rsp_data_ff <= RSP_DATA_W'({TPOS_W'(tpos_prod), step_ff, tx_q_ff, wf_q_ff});
      end
   end

   assign rsp_tdata = rsp_data_ff;

endmodule : raycast_wall_texture_coord_core

`default_nettype wire
